/* src/sdft_pkg.sv */
// Shared constants, types and the twiddle generator for the sliding DFT block.
package sdft_pkg;

  localparam int WINDOW_DEF      = 128;
  localparam int SAMPLE_BITS_DEF = 16;

  localparam int IN_W   = 16;   // sample port width
  localparam int IDX_W  = 6;    // bin_index port width
  localparam int BIN_W  = 24;   // bin part width
  localparam int MAG_W  = 24;   // magnitude width
  localparam int POW_W  = 48;   // bin power width
  localparam int TOT_W  = 40;   // running total width
  localparam int TW_W   = 16;   // Q1.15 twiddle part width
  localparam int QDEPTH = 2;    // front-to-back queue depth
  localparam int ODEPTH = 2;    // result queue depth

  localparam int     CORDIC_STAGES = 24;
  localparam longint CORDIC_START  = 652032874;
  localparam longint ATAN_TURNS [CORDIC_STAGES] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861, 10430, 5215,
    2608, 1304, 652, 326, 163, 81
  };

  // per-sample control handed from front to back
  typedef struct packed {
    logic bins_valid;  // bins have been written at least once
    logic tot_valid;   // window was already full: history and totals are live
    logic filled;      // totals accumulate on this sample
  } sdft_flags_t;

  // Elaboration-time CORDIC: phase in 2^-32 turn, returns {cos, sin} in Q1.15.
  function automatic logic [2*TW_W-1:0] twiddle(input longint phase);
    longint     x;
    longint     y;
    longint     z;
    longint     dx;
    longint     dy;
    longint     xc;
    longint     yc;
    longint     c;
    longint     s;
    logic [1:0] quad;
    quad = 2'(phase >>> 30);
    z    = phase & 64'h3FFF_FFFF;
    x    = CORDIC_START;
    y    = 0;
    for (int i = 0; i < CORDIC_STAGES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - ATAN_TURNS[i];
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + ATAN_TURNS[i];
      end
    end
    case (quad)
      2'd0: begin
        xc = x;
        yc = y;
      end
      2'd1: begin
        xc = -y;
        yc = x;
      end
      2'd2: begin
        xc = -x;
        yc = -y;
      end
      default: begin
        xc = y;
        yc = -x;
      end
    endcase
    c = (xc + 16384) >>> 15;
    s = (yc + 16384) >>> 15;
    if (c > 32767) c = 32767;
    if (c < -32768) c = -32768;
    if (s > 32767) s = 32767;
    if (s < -32768) s = -32768;
    return {TW_W'(c), TW_W'(s)};
  endfunction

endpackage

/* src/sdft_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module sdft_ram
  import sdft_pkg::*;
#(
  parameter int W     = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [W-1:0]             wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [W-1:0]             rdata_o
);

  logic [W-1:0] mem_q [DEPTH];
  logic [W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    if (re_i) rdata_q <= mem_q[raddr_i];  // read-before-write on a shared address
  end

  assign rdata_o = rdata_q;

endmodule

/* src/sdft_fifo.sv */
// Small register queue with show-ahead read.
module sdft_fifo
  import sdft_pkg::*;
#(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] wdata_i,
  input  logic         pop_i,
  output logic [W-1:0] rdata_o,
  output logic         empty_o,
  output logic         full_o
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_q [DEPTH];
  logic [AW-1:0] wptr_q, rptr_q;
  logic [CW-1:0] cnt_q;
  logic          do_push, do_pop;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == CW'(DEPTH));
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) wptr_q <= (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
      if (do_pop)  rptr_q <= (rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
      if (do_push && !do_pop) cnt_q <= cnt_q + 1'b1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wptr_q] <= wdata_i;
  end

endmodule

/* src/sdft_front.sv */
// Front end: takes samples, keeps the sample history and forms new-minus-old.
module sdft_front
  import sdft_pkg::*;
#(
  parameter int WINDOW      = WINDOW_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push,
  output logic                          full,
  input  logic signed [IN_W-1:0]        sample_re_i,
  input  logic signed [IN_W-1:0]        sample_im_i,
  output logic                          q_push_o,
  output logic signed [SAMPLE_BITS:0]   q_delta_re_o,
  output logic signed [SAMPLE_BITS:0]   q_delta_im_o,
  output sdft_flags_t                   q_flags_o,
  input  logic                          q_full_i
);

  localparam int SB = SAMPLE_BITS;
  localparam int DW = SB + 1;
  localparam int AW = $clog2(WINDOW);
  localparam int CW = $clog2(WINDOW + 1);
  localparam int XW = (SB > IN_W) ? SB : IN_W;

  logic [AW-1:0]        ptr_q;
  logic [CW-1:0]        seen_q;
  logic                 pend_q;
  logic signed [SB-1:0] new_re_q, new_im_q;
  sdft_flags_t          flags_q;

  logic [XW-1:0]        re_ext, im_ext;
  logic signed [SB-1:0] new_re, new_im;
  logic signed [SB-1:0] old_re, old_im;
  logic [2*SB-1:0]      hist_rd;
  logic                 accept, seen_full;

  // only the low SAMPLE_BITS of each part count, as two's complement
  assign re_ext = XW'($unsigned(sample_re_i));
  assign im_ext = XW'($unsigned(sample_im_i));
  assign new_re = signed'(re_ext[SB-1:0]);
  assign new_im = signed'(im_ext[SB-1:0]);

  // one sample in flight to the queue at a time
  assign full      = pend_q || q_full_i;
  assign accept    = push && !full;
  assign seen_full = (seen_q == CW'(WINDOW));

  sdft_ram #(.W(2 * SB), .DEPTH(WINDOW)) u_hist (
    .clk_i   (clk_i),
    .we_i    (accept),
    .waddr_i (ptr_q),
    .wdata_i ({new_re, new_im}),
    .re_i    (accept),
    .raddr_i (ptr_q),
    .rdata_o (hist_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q  <= '0;
      seen_q <= '0;
      pend_q <= 1'b0;
    end else begin
      pend_q <= accept;
      if (accept) begin
        ptr_q <= (ptr_q == AW'(WINDOW - 1)) ? '0 : ptr_q + 1'b1;
        if (!seen_full) seen_q <= seen_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      new_re_q           <= new_re;
      new_im_q           <= new_im;
      flags_q.bins_valid <= (seen_q != '0);
      flags_q.tot_valid  <= seen_full;
      flags_q.filled     <= (seen_q >= CW'(WINDOW - 1));
    end
  end

  // history slot is unwritten until the window has wrapped once
  assign old_re = flags_q.tot_valid ? signed'(hist_rd[2*SB-1:SB]) : '0;
  assign old_im = flags_q.tot_valid ? signed'(hist_rd[SB-1:0]) : '0;

  assign q_push_o     = pend_q;
  assign q_delta_re_o = DW'(new_re_q) - DW'(old_re);
  assign q_delta_im_o = DW'(new_im_q) - DW'(old_im);
  assign q_flags_o    = flags_q;

endmodule

/* src/sdft_isqrt.sv */
// Pipelined integer square root, one result bit per stage, with a side tag.
module sdft_isqrt
  import sdft_pkg::*;
#(
  parameter int RAD_W = POW_W,
  parameter int TAG_W = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic [RAD_W-1:0]     rad_i,
  input  logic [TAG_W-1:0]     tag_i,
  output logic                 valid_o,
  output logic [RAD_W/2-1:0]   root_o,
  output logic [TAG_W-1:0]     tag_o
);

  localparam int OW = RAD_W / 2;

  logic [RAD_W-1:0] rem_q  [OW];
  logic [OW-1:0]    root_q [OW];
  logic [TAG_W-1:0] tag_q  [OW];
  logic             v_q    [OW];

  for (genvar j = 0; j < OW; j++) begin : g_st
    localparam int B = OW - 1 - j;
    logic [RAD_W-1:0] rem_in, test;
    logic [OW-1:0]    root_in;
    logic [TAG_W-1:0] tag_in;
    logic             v_in;

    if (j == 0) begin : g_first
      assign rem_in  = rad_i;
      assign root_in = '0;
      assign tag_in  = tag_i;
      assign v_in    = valid_i;
    end else begin : g_next
      assign rem_in  = rem_q[j-1];
      assign root_in = root_q[j-1];
      assign tag_in  = tag_q[j-1];
      assign v_in    = v_q[j-1];
    end

    // (r + 2^B)^2 - r^2, r holding only bits above B
    assign test = (RAD_W'(root_in) << (B + 1)) | (RAD_W'(1) << (2 * B));

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[j] <= 1'b0;
      end else if (en_i) begin
        v_q[j] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        tag_q[j] <= tag_in;
        if (rem_in >= test) begin
          rem_q[j]  <= rem_in - test;
          root_q[j] <= root_in | (OW'(1) << B);
        end else begin
          rem_q[j]  <= rem_in;
          root_q[j] <= root_in;
        end
      end
    end
  end

  assign valid_o = v_q[OW-1];
  assign root_o  = root_q[OW-1];
  assign tag_o   = tag_q[OW-1];

endmodule

/* src/sdft_back.sv */
// Back end: sweeps the bins of one sample through rotate, magnitude and total.
module sdft_back
  import sdft_pkg::*;
#(
  parameter int WINDOW      = WINDOW_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        q_empty_i,
  output logic                        q_pop_o,
  input  logic signed [SAMPLE_BITS:0] q_delta_re_i,
  input  logic signed [SAMPLE_BITS:0] q_delta_im_i,
  input  sdft_flags_t                 q_flags_i,
  input  logic                        of_full_i,
  output logic                        of_push_o,
  output logic [IDX_W-1:0]            res_index_o,
  output logic signed [BIN_W-1:0]     res_re_o,
  output logic signed [BIN_W-1:0]     res_im_o,
  output logic [MAG_W-1:0]            res_mag_o,
  output logic [TOT_W-1:0]            res_total_o,
  output logic                        res_last_o
);

  localparam int NBINS = WINDOW / 2;
  localparam int KW    = $clog2(NBINS);
  localparam int CNTW  = $clog2(NBINS + 1);
  localparam int DW    = SAMPLE_BITS + 1;
  localparam int UW    = ((DW > BIN_W) ? DW : BIN_W) + 1;
  localparam int PW    = UW + TW_W;
  localparam int SW    = PW + 1;
  localparam int TAG_W = KW + 2 * BIN_W + TOT_W;
  localparam logic signed [SW-1:0] BMAX = SW'(2 ** (BIN_W - 1) - 1);
  localparam logic signed [SW-1:0] BMIN = -BMAX - SW'(1);

  typedef enum logic [1:0] {S_IDLE, S_SWEEP, S_DRAIN} state_e;

  state_e                state_q;
  logic [KW-1:0]         k_q;
  logic [CNTW-1:0]       infl_q;
  logic signed [DW-1:0]  dre_q, dim_q;
  sdft_flags_t           flags_q;

  // twiddle ROM, built at elaboration
  logic [2*TW_W-1:0] tw [NBINS];
  for (genvar g = 0; g < NBINS; g++) begin : g_tw
    localparam longint PH = (longint'(g) << 32) / WINDOW;
    assign tw[g] = twiddle(PH);
  end

  logic adv, issue, push;
  logic [2*BIN_W-1:0] bin_rd;
  logic [TOT_W-1:0]   tot_rd;

  // stage registers
  logic                    v0_q, v1_q, v2_q, v3_q, v4_q, v5_q;
  logic [KW-1:0]           k0_q, k1_q, k2_q, k3_q, k4_q, k5_q;
  logic signed [UW-1:0]    ur1_q, ui1_q;
  logic signed [TW_W-1:0]  c1_q, s1_q;
  logic [TOT_W-1:0]        tot1_q, tot2_q, tot3_q, tot4_q, tot5_q;
  logic signed [PW-1:0]    prc2_q, pis2_q, prs2_q, pic2_q;
  logic signed [BIN_W-1:0] vr3_q, vi3_q, vr4_q, vi4_q, vr5_q, vi5_q;
  logic signed [2*BIN_W-1:0] sqr4_q, sqi4_q;
  logic [POW_W-1:0]        pow5_q;

  logic signed [UW-1:0]    ur_d, ui_d;
  logic signed [PW-1:0]    prc_d, pis_d, prs_d, pic_d;
  logic signed [SW-1:0]    re_sum, im_sum, re_rnd, im_rnd;
  logic signed [BIN_W-1:0] vr_d, vi_d;
  logic signed [2*BIN_W-1:0] sqr_d, sqi_d;

  logic             sq_v;
  logic [MAG_W-1:0] sq_root;
  logic [TAG_W-1:0] sq_tag;
  logic [KW-1:0]    e_k;
  logic [TOT_W-1:0] e_tot;
  logic [TOT_W:0]   tot_sum;
  logic [TOT_W-1:0] tot_new;

  function automatic logic signed [BIN_W-1:0] sat_bin(input logic signed [SW-1:0] v);
    if (v > BMAX) return BMAX[BIN_W-1:0];
    if (v < BMIN) return BMIN[BIN_W-1:0];
    return v[BIN_W-1:0];
  endfunction

  // the whole pipe holds when a finished result finds the result queue full
  assign push    = sq_v && !of_full_i;
  assign adv     = !(sq_v && of_full_i);
  assign issue   = (state_q == S_SWEEP) && adv;
  assign q_pop_o = (state_q == S_IDLE) && !q_empty_i;

  // sequencer: one sample at a time, drained before the next reads its bins
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      k_q     <= '0;
      infl_q  <= '0;
    end else begin
      infl_q <= infl_q + CNTW'(issue) - CNTW'(push);
      case (state_q)
        S_IDLE: begin
          if (!q_empty_i) begin
            state_q <= S_SWEEP;
            k_q     <= '0;
          end
        end
        S_SWEEP: begin
          if (issue) begin
            k_q <= k_q + 1'b1;
            if (k_q == KW'(NBINS - 1)) state_q <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (infl_q == '0) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      dre_q   <= q_delta_re_i;
      dim_q   <= q_delta_im_i;
      flags_q <= q_flags_i;
    end
  end

  sdft_ram #(.W(2 * BIN_W), .DEPTH(NBINS)) u_bins (
    .clk_i   (clk_i),
    .we_i    (v3_q),
    .waddr_i (k3_q),
    .wdata_i ({vr3_q, vi3_q}),
    .re_i    (issue),
    .raddr_i (k_q),
    .rdata_o (bin_rd)
  );

  sdft_ram #(.W(TOT_W), .DEPTH(NBINS)) u_tot (
    .clk_i   (clk_i),
    .we_i    (push),
    .waddr_i (e_k),
    .wdata_i (tot_new),
    .re_i    (issue),
    .raddr_i (k_q),
    .rdata_o (tot_rd)
  );

  // datapath
  always_comb begin
    ur_d = '0;
    ui_d = '0;
    if (flags_q.bins_valid) begin
      ur_d = UW'(signed'(bin_rd[2*BIN_W-1:BIN_W]));
      ui_d = UW'(signed'(bin_rd[BIN_W-1:0]));
    end
    ur_d = ur_d + UW'(dre_q);
    ui_d = ui_d + UW'(dim_q);
  end

  assign prc_d  = ur1_q * c1_q;
  assign pis_d  = ui1_q * s1_q;
  assign prs_d  = ur1_q * s1_q;
  assign pic_d  = ui1_q * c1_q;
  assign re_sum = SW'(prc2_q) - SW'(pis2_q) + SW'(16384);
  assign im_sum = SW'(prs2_q) + SW'(pic2_q) + SW'(16384);
  assign re_rnd = re_sum >>> 15;
  assign im_rnd = im_sum >>> 15;
  assign vr_d   = sat_bin(re_rnd);
  assign vi_d   = sat_bin(im_rnd);
  assign sqr_d  = vr3_q * vr3_q;
  assign sqi_d  = vi3_q * vi3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else if (adv) begin
      v0_q <= issue;
      v1_q <= v0_q;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      k0_q   <= k_q;
      k1_q   <= k0_q;
      ur1_q  <= ur_d;
      ui1_q  <= ui_d;
      c1_q   <= signed'(tw[k0_q][2*TW_W-1:TW_W]);
      s1_q   <= signed'(tw[k0_q][TW_W-1:0]);
      tot1_q <= flags_q.tot_valid ? tot_rd : '0;
      k2_q   <= k1_q;
      prc2_q <= prc_d;
      pis2_q <= pis_d;
      prs2_q <= prs_d;
      pic2_q <= pic_d;
      tot2_q <= tot1_q;
      k3_q   <= k2_q;
      vr3_q  <= vr_d;
      vi3_q  <= vi_d;
      tot3_q <= tot2_q;
      k4_q   <= k3_q;
      vr4_q  <= vr3_q;
      vi4_q  <= vi3_q;
      sqr4_q <= sqr_d;
      sqi4_q <= sqi_d;
      tot4_q <= tot3_q;
      k5_q   <= k4_q;
      vr5_q  <= vr4_q;
      vi5_q  <= vi4_q;
      pow5_q <= $unsigned(sqr4_q) + $unsigned(sqi4_q);
      tot5_q <= tot4_q;
    end
  end

  sdft_isqrt #(.RAD_W(POW_W), .TAG_W(TAG_W)) u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (v5_q),
    .rad_i   (pow5_q),
    .tag_i   ({k5_q, vr5_q, vi5_q, tot5_q}),
    .valid_o (sq_v),
    .root_o  (sq_root),
    .tag_o   (sq_tag)
  );

  assign e_k     = sq_tag[TAG_W-1 -: KW];
  assign e_tot   = sq_tag[TOT_W-1:0];
  assign tot_sum = {1'b0, e_tot} + (TOT_W + 1)'(sq_root);
  assign tot_new = !flags_q.filled ? e_tot :
                   (tot_sum[TOT_W] ? '1 : tot_sum[TOT_W-1:0]);

  assign of_push_o   = push;
  assign res_index_o = IDX_W'(e_k);
  assign res_re_o    = signed'(sq_tag[TOT_W+2*BIN_W-1:TOT_W+BIN_W]);
  assign res_im_o    = signed'(sq_tag[TOT_W+BIN_W-1:TOT_W]);
  assign res_mag_o   = sq_root;
  assign res_total_o = tot_new;
  assign res_last_o  = (e_k == KW'(NBINS - 1));

endmodule

/* src/sliding_dft_magnitude_accumulator.sv */
// Top level of the sliding DFT bin bank with magnitude accumulation.
//
// Each complex sample updates bins 0 .. WINDOW/2-1 of a sliding DFT: the bin
// gets the new sample minus the one leaving the window, is rotated by a Q1.15
// twiddle and saturated to 24 bits, then its magnitude (floor square root of
// the power) is added to a saturating per-bin total once the window is full.
// Every sample yields WINDOW/2 results in ascending bin order, the last one
// flagged by last_bin_o. The front end takes one sample at a time into a
// two-entry queue; the back end issues one bin per cycle while the result
// queue can take its results, and must let its pipeline drain before it
// reads the bins of the next sample, because bin k of one sample feeds bin k
// of the next. Between samples the back end thus waits for its six rotate
// and square stages and the 24-stage square root to empty, then passes the
// drain check and pops the next sample. The result side is a two-entry
// queue; when a finished result finds it full the whole back-end pipeline
// holds. All state starts at zero after reset, with no clearing pass.
module sliding_dft_magnitude_accumulator
  import sdft_pkg::*;
#(
  parameter int WINDOW      = WINDOW_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push,
  output logic                    full,
  input  logic signed [IN_W-1:0]  sample_re_i,
  input  logic signed [IN_W-1:0]  sample_im_i,
  output logic                    empty,
  input  logic                    pop,
  output logic [IDX_W-1:0]        bin_index_o,
  output logic signed [BIN_W-1:0] bin_re_o,
  output logic signed [BIN_W-1:0] bin_im_o,
  output logic [MAG_W-1:0]        magnitude_o,
  output logic [TOT_W-1:0]        magnitude_total_o,
  output logic                    last_bin_o
);

  localparam int DW   = SAMPLE_BITS + 1;
  localparam int QW   = 2 * DW + $bits(sdft_flags_t);
  localparam int OW   = IDX_W + 2 * BIN_W + MAG_W + TOT_W + 1;

  // front to queue
  logic                 f_push;
  logic signed [DW-1:0] f_dre, f_dim;
  sdft_flags_t          f_flags;
  logic                 q_full, q_empty, q_pop;
  logic [QW-1:0]        q_rd;

  // back to result queue
  logic                    o_push, o_full;
  logic [IDX_W-1:0]        r_idx;
  logic signed [BIN_W-1:0] r_re, r_im;
  logic [MAG_W-1:0]        r_mag;
  logic [TOT_W-1:0]        r_tot;
  logic                    r_last;
  logic [OW-1:0]           o_rd;

  sdft_front #(.WINDOW(WINDOW), .SAMPLE_BITS(SAMPLE_BITS)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .sample_re_i  (sample_re_i),
    .sample_im_i  (sample_im_i),
    .q_push_o     (f_push),
    .q_delta_re_o (f_dre),
    .q_delta_im_o (f_dim),
    .q_flags_o    (f_flags),
    .q_full_i     (q_full)
  );

  sdft_fifo #(.W(QW), .DEPTH(QDEPTH)) u_cmdq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_push),
    .wdata_i ({f_dre, f_dim, f_flags}),
    .pop_i   (q_pop),
    .rdata_o (q_rd),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  sdft_back #(.WINDOW(WINDOW), .SAMPLE_BITS(SAMPLE_BITS)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_empty_i    (q_empty),
    .q_pop_o      (q_pop),
    .q_delta_re_i (signed'(q_rd[QW-1 -: DW])),
    .q_delta_im_i (signed'(q_rd[QW-DW-1 -: DW])),
    .q_flags_i    (sdft_flags_t'(q_rd[$bits(sdft_flags_t)-1:0])),
    .of_full_i    (o_full),
    .of_push_o    (o_push),
    .res_index_o  (r_idx),
    .res_re_o     (r_re),
    .res_im_o     (r_im),
    .res_mag_o    (r_mag),
    .res_total_o  (r_tot),
    .res_last_o   (r_last)
  );

  sdft_fifo #(.W(OW), .DEPTH(ODEPTH)) u_resq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (o_push),
    .wdata_i ({r_idx, r_re, r_im, r_mag, r_tot, r_last}),
    .pop_i   (pop),
    .rdata_o (o_rd),
    .empty_o (empty),
    .full_o  (o_full)
  );

  assign bin_index_o       = o_rd[OW-1 -: IDX_W];
  assign bin_re_o          = signed'(o_rd[OW-IDX_W-1 -: BIN_W]);
  assign bin_im_o          = signed'(o_rd[OW-IDX_W-BIN_W-1 -: BIN_W]);
  assign magnitude_o       = o_rd[TOT_W+MAG_W:TOT_W+1];
  assign magnitude_total_o = o_rd[TOT_W:1];
  assign last_bin_o        = o_rd[0];

endmodule

/* src/sdft_checker.sv */
// Port-level checks for the sliding DFT block, bound to its top level.
module sdft_checker
  import sdft_pkg::*;
#(
  parameter int WINDOW = WINDOW_DEF
) (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    empty,
  input logic                    pop,
  input logic [IDX_W-1:0]        bin_index_o,
  input logic signed [BIN_W-1:0] bin_re_o,
  input logic signed [BIN_W-1:0] bin_im_o,
  input logic [MAG_W-1:0]        magnitude_o,
  input logic [TOT_W-1:0]        magnitude_total_o,
  input logic                    last_bin_o
);

  localparam logic [IDX_W-1:0] LAST = IDX_W'(WINDOW / 2 - 1);

  logic [IDX_W-1:0] exp_q;
  logic [BIN_W:0]   abs_re, abs_im;

  // bins leave in ascending order, wrapping after the last one
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_q <= '0;
    end else if (pop && !empty) begin
      exp_q <= (exp_q == LAST) ? '0 : exp_q + 1'b1;
    end
  end

  assign abs_re = bin_re_o[BIN_W-1] ? -{1'b1, bin_re_o} : {1'b0, bin_re_o};
  assign abs_im = bin_im_o[BIN_W-1] ? -{1'b1, bin_im_o} : {1'b0, bin_im_o};

  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> bin_index_o == exp_q)
    else $error("result bin out of order");

  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> last_bin_o == (bin_index_o == LAST))
    else $error("last_bin flag does not match bin index");

  a_mag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> ({1'b0, magnitude_o} >= abs_re) && ({1'b0, magnitude_o} >= abs_im))
    else $error("magnitude below a bin part");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(bin_index_o) && $stable(bin_re_o)
                          && $stable(magnitude_total_o)))
    else $error("waiting result changed");

endmodule

bind sliding_dft_magnitude_accumulator sdft_checker #(.WINDOW(WINDOW)) u_sdft_checker (.*);

/* dv/tb_sliding_dft_magnitude_accumulator.sv */
// Testbench for the sliding DFT bin bank with magnitude accumulation.
`timescale 1ns / 1ps

module tb_sliding_dft_magnitude_accumulator;
  import sdft_pkg::*;

  localparam int NWIN       = WINDOW_DEF;
  localparam int NBIN       = NWIN / 2;
  localparam int IDLE_LIMIT = 3000;   // cycles without any transfer
  localparam int LONG_HOLD  = 500;    // receiver hold-off to fill the block
  localparam int N_RANDOM   = 360;

  typedef struct {
    logic [IDX_W-1:0]        idx;
    logic signed [BIN_W-1:0] re;
    logic signed [BIN_W-1:0] im;
    logic [MAG_W-1:0]        mag;
    logic [TOT_W-1:0]        tot;
    logic                    last;
  } bin_result_t;

  // Tracks history, bins and totals; keeps the bin results still owed.
  class bin_scoreboard;
    longint      hist_re [NWIN];
    longint      hist_im [NWIN];
    int          wr_ptr;
    int          seen;
    longint      bin_re [NBIN];
    longint      bin_im [NBIN];
    longint      totals [NBIN];
    longint      tw_cos [NBIN];
    longint      tw_sin [NBIN];
    bin_result_t owed_bins[$];
    int          errors;

    function new();
      longint x, y, z, dx, dy, xc, yc, phase;
      int     quad;
      for (int k = 0; k < NBIN; k++) begin
        phase = (longint'(k) << 32) / NWIN;
        quad  = int'(phase >> 30);
        z     = phase & 64'h3FFF_FFFF;
        x     = CORDIC_START;
        y     = 0;
        for (int i = 0; i < CORDIC_STAGES; i++) begin
          dx = y >>> i;
          dy = x >>> i;
          if (z >= 0) begin
            x -= dx; y += dy; z -= ATAN_TURNS[i];
          end else begin
            x += dx; y -= dy; z += ATAN_TURNS[i];
          end
        end
        case (quad)
          0: begin xc = x;  yc = y;  end
          1: begin xc = -y; yc = x;  end
          2: begin xc = -x; yc = -y; end
          default: begin xc = y; yc = -x; end
        endcase
        tw_cos[k] = clamp((xc + 16384) >>> 15, -32768, 32767);
        tw_sin[k] = clamp((yc + 16384) >>> 15, -32768, 32767);
        hist_re[k] = 0;
        bin_re[k] = 0;
        bin_im[k] = 0;
        totals[k] = 0;
      end
      foreach (hist_re[i]) begin
        hist_re[i] = 0;
        hist_im[i] = 0;
      end
      wr_ptr = 0;
      seen   = 0;
      errors = 0;
    endfunction

    static function longint clamp(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // floor square root, bit-pair method
    static function longint root_floor(longint n);
      longint res, bitv;
      res  = 0;
      bitv = 64'sh1 << 62;
      while (bitv > n) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (n >= res + bitv) begin
          n   = n - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
        bitv = bitv >> 2;
      end
      return res;
    endfunction

    task report(string msg);
      errors++;
      $display("MISMATCH @%0t: %s", $time, msg);
    endtask

    // one accepted sample: slide the window and update every bin
    function void note_sample(logic signed [IN_W-1:0] s_re, logic signed [IN_W-1:0] s_im);
      longint      old_re, old_im, ur, ui, vr, vi, mag;
      bin_result_t r;
      old_re = hist_re[wr_ptr];
      old_im = hist_im[wr_ptr];
      hist_re[wr_ptr] = s_re;
      hist_im[wr_ptr] = s_im;
      wr_ptr = (wr_ptr + 1) % NWIN;
      if (seen < NWIN) seen++;
      for (int k = 0; k < NBIN; k++) begin
        ur = bin_re[k] + longint'(s_re) - old_re;
        ui = bin_im[k] + longint'(s_im) - old_im;
        vr = clamp((ur * tw_cos[k] - ui * tw_sin[k] + 16384) >>> 15, -8388608, 8388607);
        vi = clamp((ur * tw_sin[k] + ui * tw_cos[k] + 16384) >>> 15, -8388608, 8388607);
        bin_re[k] = vr;
        bin_im[k] = vi;
        mag = root_floor(vr * vr + vi * vi);
        if (seen >= NWIN) totals[k] = clamp(totals[k] + mag, 0, 64'hFF_FFFF_FFFF);
        r.idx  = IDX_W'(k);
        r.re   = BIN_W'(vr);
        r.im   = BIN_W'(vi);
        r.mag  = MAG_W'(mag);
        r.tot  = TOT_W'(totals[k]);
        r.last = (k == NBIN - 1);
        owed_bins.push_back(r);
      end
    endfunction

    task check_result(bin_result_t got);
      bin_result_t e;
      if (owed_bins.size() == 0) begin
        report($sformatf("unexpected result for bin %0d", got.idx));
        return;
      end
      e = owed_bins.pop_front();
      if (got.idx != e.idx) report($sformatf("bin_index %0d, want %0d", got.idx, e.idx));
      if (got.re !== e.re)
        report($sformatf("bin %0d bin_re %0d, want %0d", e.idx, got.re, e.re));
      if (got.im !== e.im)
        report($sformatf("bin %0d bin_im %0d, want %0d", e.idx, got.im, e.im));
      if (got.mag !== e.mag)
        report($sformatf("bin %0d magnitude %0d, want %0d", e.idx, got.mag, e.mag));
      if (got.tot !== e.tot)
        report($sformatf("bin %0d magnitude_total %0d, want %0d", e.idx, got.tot, e.tot));
      if (got.last !== e.last)
        report($sformatf("bin %0d last_bin %0b, want %0b", e.idx, got.last, e.last));
    endtask
  endclass

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    push = 1'b0;
  logic                    pop = 1'b0;
  logic                    full;
  logic                    empty;
  logic signed [IN_W-1:0]  sample_re_i = '0;
  logic signed [IN_W-1:0]  sample_im_i = '0;
  logic [IDX_W-1:0]        bin_index_o;
  logic signed [BIN_W-1:0] bin_re_o;
  logic signed [BIN_W-1:0] bin_im_o;
  logic [MAG_W-1:0]        magnitude_o;
  logic [TOT_W-1:0]        magnitude_total_o;
  logic                    last_bin_o;

  bin_scoreboard sb = new();
  bit            calm_phase = 0;   // no idling on either side near the end
  bit            hold_request = 0; // receiver goes quiet for a long stretch
  int            quiet_cycles = 0;

  always #6 clk_i = ~clk_i;

  sliding_dft_magnitude_accumulator u_dut (
    .clk_i, .rst_ni, .push, .full, .sample_re_i, .sample_im_i,
    .empty, .pop, .bin_index_o, .bin_re_o, .bin_im_o,
    .magnitude_o, .magnitude_total_o, .last_bin_o
  );

  // result monitor: a transfer is pop && !empty at the rising edge
  always @(posedge clk_i) begin
    bin_result_t got;
    if (rst_ni && pop && !empty) begin
      got.idx  = bin_index_o;
      got.re   = bin_re_o;
      got.im   = bin_im_o;
      got.mag  = magnitude_o;
      got.tot  = magnitude_total_o;
      got.last = last_bin_o;
      sb.check_result(got);
    end
  end

  // watchdog: any transfer on either side clears the count
  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty)) begin
      quiet_cycles <= 0;
    end else if (rst_ni) begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // receiver: random stall bursts, plus one long hold-off on request
  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      if (hold_request) begin
        hold_request = 0;
        repeat (LONG_HOLD) @(negedge clk_i) pop <= 1'b0;
      end else if (!calm_phase && $urandom_range(0, 7) == 0) begin
        n = $urandom_range(1, 14);
        repeat (n) @(negedge clk_i) pop <= 1'b0;
      end else begin
        @(negedge clk_i) pop <= 1'b1;
      end
    end
  end

  // one sample transfer; idle burst first at random outside the calm phase
  task send_sample(logic signed [IN_W-1:0] re, logic signed [IN_W-1:0] im);
    int n;
    if (!calm_phase && $urandom_range(0, 5) == 0) begin
      n = $urandom_range(1, 14);
      repeat (n) @(negedge clk_i) push <= 1'b0;
    end
    @(negedge clk_i);
    push        <= 1'b1;
    sample_re_i <= re;
    sample_im_i <= im;
    do @(posedge clk_i); while (full);
    sb.note_sample(re, im);
  endtask

  function automatic logic signed [IN_W-1:0] pick_value();
    case ($urandom_range(0, 5))
      0: return 16'sh7FFF;
      1: return -16'sh8000;
      2: return IN_W'($urandom_range(0, 15)) - 16'sd8;
      default: return IN_W'($urandom());
    endcase
  endfunction

  initial begin
    logic signed [IN_W-1:0] lvl_re, lvl_im;
    int                     run_len, mode, sent;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    // directed: zero, corners of the range, bit patterns, a full-scale run
    send_sample(16'sd0, 16'sd0);
    send_sample(16'sh7FFF, 16'sh7FFF);
    send_sample(-16'sh8000, -16'sh8000);
    send_sample(16'sh7FFF, -16'sh8000);
    send_sample(-16'sh8000, 16'sh7FFF);
    send_sample(16'sd1, -16'sd1);
    send_sample(-16'sd1, 16'sd1);
    send_sample(16'sh5555, -16'sh5556);
    send_sample(-16'sh5556, 16'sh5555);
    for (int i = 0; i < 12; i++) send_sample(16'sh7FFF, -16'sh8000);

    // random: the receiver stalls long at the start so the input backs up
    hold_request = 1;
    sent = 0;
    while (sent < N_RANDOM) begin
      if (sent >= N_RANDOM - 60) calm_phase = 1;
      mode    = $urandom_range(0, 3);
      run_len = $urandom_range(4, 40);
      // one long constant run pushes the DC bin toward its largest value
      if (sent == 40) begin
        mode    = 0;
        run_len = 140;
      end
      lvl_re = pick_value();
      lvl_im = pick_value();
      for (int i = 0; i < run_len && sent < N_RANDOM; i++) begin
        case (mode)
          0: send_sample(lvl_re, lvl_im);                       // constant level
          1: send_sample(i[0] ? lvl_re : -lvl_re, i[0] ? -lvl_im : lvl_im); // alternating
          2: send_sample(IN_W'($urandom()), IN_W'($urandom())); // noise
          default: send_sample(pick_value(), pick_value());
        endcase
        sent++;
      end
    end
    @(negedge clk_i) push <= 1'b0;

    // drain; the watchdog covers a stuck block
    while (sb.owed_bins.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (sb.owed_bins.size() != 0) sb.report("results still owed at end");
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* sliding_dft_magnitude_accumulator.f */
src/sdft_pkg.sv
src/sdft_ram.sv
src/sdft_fifo.sv
src/sdft_front.sv
src/sdft_isqrt.sv
src/sdft_back.sv
src/sliding_dft_magnitude_accumulator.sv
src/sdft_checker.sv
dv/tb_sliding_dft_magnitude_accumulator.sv
